// ===== rtl/core/smis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smis_pkg
// Shared types, constants and helpers of the P-machine instruction step core.
// ----------------------------------------------------------------------------
package smis_pkg;

  localparam int STACK_DEPTH = 2048;
  localparam int CODE_DEPTH  = 512;
  localparam int MAX_LEVEL   = 15;

  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int PC_W   = $clog2(CODE_DEPTH);
  localparam int LVL_W  = 4;
  localparam int CMD_W  = 4;
  localparam int WORD_W = 32;
  // signed width for address arithmetic: word plus base plus carry
  localparam int XW     = WORD_W + 2;

  typedef enum logic [CMD_W-1:0] {
    OP_LIT = 4'd1,
    OP_OPR = 4'd2,
    OP_LOD = 4'd3,
    OP_STO = 4'd4,
    OP_CAL = 4'd5,
    OP_INC = 4'd6,
    OP_JMP = 4'd7,
    OP_JPC = 4'd8,
    OP_SIO = 4'd9,
    OP_HLT = 4'd11
  } op_t;

  typedef enum logic [3:0] {
    OPR_RET = 4'd0,
    OPR_NEG = 4'd1,
    OPR_ADD = 4'd2,
    OPR_SUB = 4'd3,
    OPR_MUL = 4'd4,
    OPR_DIV = 4'd5,
    OPR_ODD = 4'd6,
    OPR_MOD = 4'd7,
    OPR_EQL = 4'd8,
    OPR_NEQ = 4'd9,
    OPR_LSS = 4'd10,
    OPR_LEQ = 4'd11,
    OPR_GTR = 4'd12,
    OPR_GEQ = 4'd13
  } opr_t;

  localparam logic [WORD_W-1:0] SIO_WRITE = 32'd0;
  localparam logic [WORD_W-1:0] SIO_READ  = 32'd1;
  localparam logic [WORD_W-1:0] SIO_HALT  = 32'd2;
  localparam logic [WORD_W-1:0] HLT_CODE  = 32'd3;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_DIV0  = 2'd1,
    FLT_STACK = 2'd2,
    FLT_PC    = 2'd3
  } fault_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_WALK_W,
    ST_CHECK,
    ST_RD2,
    ST_EXE,
    ST_DIV,
    ST_FIN,
    ST_WR,
    ST_CMT,
    ST_TOP,
    ST_OUT
  } smis_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [LVL_W-1:0]         level;
    logic signed [WORD_W-1:0] operand;
    logic signed [WORD_W-1:0] read_value;
  } in_item_t;

  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic [SP_W-1:0]          frame_base;
    logic [SP_W-1:0]          stack_pointer;
    logic signed [WORD_W-1:0] top_value;
    logic                     write_valid;
    logic signed [WORD_W-1:0] write_value;
    logic                     halted;
    logic [1:0]               fault;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic walk_step;
    logic walk_ld;
    logic chk;
    logic rd2;
    logic exe;
    logic div_ld;
    logic fin;
    logic wr;
    logic cmt;
    logic out_ld;
  } smis_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic halted;
    logic walk_zero;
    logic walk_bad;
    logic stk_bad;
    logic need_div;
    logic div_done;
    logic commit_ok;
    logic has_wr;
    logic wr_last;
    logic out_free;
  } smis_sts_t;

  function automatic logic signed [XW-1:0] sext_w(input logic [WORD_W-1:0] w);
    return {{(XW-WORD_W){w[WORD_W-1]}}, w};
  endfunction

  function automatic logic signed [XW-1:0] zext_sp(input logic [SP_W-1:0] s);
    return {{(XW-SP_W){1'b0}}, s};
  endfunction

  function automatic logic in_stk(input logic signed [XW-1:0] v);
    return !v[XW-1] && (v < $signed(XW'(STACK_DEPTH)));
  endfunction

  function automatic logic in_code(input logic signed [XW-1:0] v);
    return !v[XW-1] && (v < $signed(XW'(CODE_DEPTH)));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/smis_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smis_if
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
interface smis_in_if;
  import smis_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface smis_out_if;
  import smis_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/smis_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smis_div
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module smis_div
  import smis_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   done,
  output logic [WORD_W-1:0]      quo,
  output logic [WORD_W-1:0]      rem
);

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0] n_r, d_r, rem_r;
  logic             negq_r, negr_r;

  logic [WORD_W:0]   rt, diff;
  logic [WORD_W-1:0] abs_x, abs_y;

  assign abs_x = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
  assign abs_y = divisor[WORD_W-1]  ? (~divisor + 1'b1)  : divisor;

  // shift in the next dividend bit and trial subtract
  assign rt   = {rem_r, n_r[WORD_W-1]};
  assign diff = rt - {1'b0, d_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(WORD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= abs_x;
      d_r    <= abs_y;
      rem_r  <= '0;
      negq_r <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      negr_r <= dividend[WORD_W-1];
    end else if (run_r) begin
      if (!diff[WORD_W]) begin
        rem_r <= diff[WORD_W-1:0];
        n_r   <= {n_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_r <= rt[WORD_W-1:0];
        n_r   <= {n_r[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = negq_r ? (~n_r + 1'b1) : n_r;
  assign rem  = negr_r ? (~rem_r + 1'b1) : rem_r;

endmodule
`default_nettype wire

// ===== rtl/core/smis_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smis_dp
// Datapath: stack memory, machine registers, address checks, ALU, result beat.
// ----------------------------------------------------------------------------
module smis_dp
  import smis_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire smis_cmd_t cmd,
  output smis_sts_t      sts,
  input  wire in_item_t  in_data,
  input  wire logic      out_ready,
  output logic           out_valid,
  output out_item_t      out_data
);

  // stack memory
  logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic [SP_W-1:0]   raddr, waddr;
  logic [WORD_W-1:0] wdata;
  logic              we;

  // machine state
  logic [SP_W-1:0] sp_r, bp_r, clr_r;
  logic [PC_W-1:0] pc_r;
  logic            halt_r;
  logic            out_vld_r;

  // per-instruction registers
  logic [CMD_W-1:0]  cmd_r;
  logic [WORD_W-1:0] m_r, rv_r, b_r, x_r, wd_r, wo_r;
  logic [LVL_W-1:0]  cnt_r;
  fault_t            fault_r;
  logic [SP_W-1:0]   nsp_r, nbp_r, wa_r;
  logic signed [XW-1:0] npc_r;
  logic              nw1_r, nw4_r, hl_r, wv_r;
  logic [1:0]        wk_r;
  out_item_t         out_r;

  logic signed [XW-1:0] sp_x, bp_x, b_x, m_x, ea, pc1_x;
  logic [PC_W:0]        pc1;
  logic                 opr_ok, walk_bad;
  logic [LVL_W-1:0]     lvl_c;
  logic [WORD_W-1:0]    y;

  // address plan
  logic            p_bad;
  logic [SP_W-1:0] p_ra, p_rb;

  // execute results
  logic [SP_W-1:0]      e_nsp, e_nbp, e_wa;
  logic signed [XW-1:0] e_npc;
  logic [WORD_W-1:0]    e_wd, e_wo;
  logic                 e_nw1, e_nw4, e_hl, e_wv, e_bad, e_isdiv;
  logic [2*WORD_W-1:0]  prod;
  logic signed [XW-1:0] ret_a;

  logic              div_done;
  logic [WORD_W-1:0] div_q, div_rem;
  logic              pc_ok;
  logic [WORD_W-1:0] cal_d;

  assign sp_x  = zext_sp(sp_r);
  assign bp_x  = zext_sp(bp_r);
  assign b_x   = sext_w(b_r);
  assign m_x   = sext_w(m_r);
  assign ea    = b_x + m_x;
  assign pc1   = {1'b0, pc_r} + 1'b1;
  assign pc1_x = {{(XW-PC_W-1){1'b0}}, pc1};
  assign y     = rdata_r;

  assign opr_ok   = (m_r[WORD_W-1:4] == '0);
  assign walk_bad = !in_stk(b_x + XW'(1));
  assign lvl_c    = (in_data.level > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : in_data.level;

  // range checks and read addresses for the instruction
  always_comb begin
    p_bad = 1'b0;
    p_ra  = sp_r;
    p_rb  = sp_r;
    case (cmd_r)
      OP_LIT: p_bad = !in_stk(sp_x + XW'(1));
      OP_OPR: begin
        if (opr_ok) begin
          case (m_r[3:0])
            OPR_RET: begin
              p_bad = !in_stk(bp_x - XW'(1)) || !in_stk(bp_x + XW'(3));
              p_ra  = bp_r + SP_W'(3);
              p_rb  = bp_r + SP_W'(2);
            end
            OPR_NEG, OPR_ODD: p_bad = 1'b0;
            OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_MOD, OPR_EQL, OPR_NEQ,
            OPR_LSS, OPR_LEQ, OPR_GTR, OPR_GEQ: begin
              p_bad = (sp_r == '0);
              p_ra  = sp_r - 1'b1;
            end
            default: p_bad = 1'b0;
          endcase
        end
      end
      OP_LOD: begin
        p_bad = !in_stk(ea) || !in_stk(sp_x + XW'(1));
        p_ra  = ea[SP_W-1:0];
      end
      OP_STO: p_bad = !in_stk(ea) || (sp_r == '0);
      OP_CAL: p_bad = !in_stk(sp_x + XW'(4));
      OP_INC: p_bad = !in_stk(sp_x + m_x);
      OP_JPC: p_bad = (sp_r == '0);
      OP_SIO: begin
        if (m_r == SIO_WRITE) p_bad = (sp_r == '0);
        else if (m_r == SIO_READ) p_bad = !in_stk(sp_x + XW'(1));
      end
      default: p_bad = 1'b0;
    endcase
  end

  // execute: operands are x_r (first read) and y (second read)
  assign prod  = {{WORD_W{1'b0}}, x_r} * {{WORD_W{1'b0}}, y};
  assign ret_a = sext_w(y);

  always_comb begin
    e_nsp   = sp_r;
    e_nbp   = bp_r;
    e_npc   = pc1_x;
    e_wa    = sp_r;
    e_wd    = '0;
    e_wo    = '0;
    e_nw1   = 1'b0;
    e_nw4   = 1'b0;
    e_hl    = 1'b0;
    e_wv    = 1'b0;
    e_bad   = 1'b0;
    e_isdiv = 1'b0;
    case (cmd_r)
      OP_LIT: begin
        e_nsp = sp_r + 1'b1;
        e_wa  = sp_r + 1'b1;
        e_wd  = m_r;
        e_nw1 = 1'b1;
      end
      OP_OPR: begin
        if (opr_ok) begin
          case (m_r[3:0])
            OPR_RET: begin
              e_npc = sext_w(x_r);
              e_bad = !in_stk(ret_a);
              e_nsp = bp_r - 1'b1;
              e_nbp = ret_a[SP_W-1:0];
              e_hl  = (bp_r <= SP_W'(1));
            end
            OPR_NEG: begin
              e_wd  = ~x_r + 1'b1;
              e_nw1 = 1'b1;
            end
            OPR_ODD: begin
              e_wd  = {{(WORD_W-1){1'b0}}, x_r[0]};
              e_nw1 = 1'b1;
            end
            default: begin
              // binary operations
              e_nsp = sp_r - 1'b1;
              e_wa  = sp_r - 1'b1;
              e_nw1 = 1'b1;
              case (m_r[3:0])
                OPR_ADD: e_wd = x_r + y;
                OPR_SUB: e_wd = x_r - y;
                OPR_MUL: e_wd = prod[WORD_W-1:0];
                OPR_DIV, OPR_MOD: e_isdiv = 1'b1;
                OPR_EQL: e_wd = WORD_W'(x_r == y);
                OPR_NEQ: e_wd = WORD_W'(x_r != y);
                OPR_LSS: e_wd = WORD_W'($signed(x_r) <  $signed(y));
                OPR_LEQ: e_wd = WORD_W'($signed(x_r) <= $signed(y));
                OPR_GTR: e_wd = WORD_W'($signed(x_r) >  $signed(y));
                OPR_GEQ: e_wd = WORD_W'($signed(x_r) >= $signed(y));
                default: begin
                  // codes fourteen and fifteen only advance the pc
                  e_nsp = sp_r;
                  e_nw1 = 1'b0;
                end
              endcase
            end
          endcase
        end
      end
      OP_LOD: begin
        e_nsp = sp_r + 1'b1;
        e_wa  = sp_r + 1'b1;
        e_wd  = x_r;
        e_nw1 = 1'b1;
      end
      OP_STO: begin
        e_wa  = ea[SP_W-1:0];
        e_wd  = x_r;
        e_nsp = sp_r - 1'b1;
        e_nw1 = 1'b1;
      end
      OP_CAL: begin
        e_wa  = sp_r + 1'b1;
        e_nbp = sp_r + 1'b1;
        e_npc = m_x;
        e_nw4 = 1'b1;
      end
      OP_INC: e_nsp = SP_W'(sp_x + m_x);
      OP_JMP: e_npc = m_x;
      OP_JPC: begin
        if (x_r == '0) e_npc = m_x;
        e_nsp = sp_r - 1'b1;
      end
      OP_SIO: begin
        if (m_r == SIO_WRITE) begin
          e_wv  = 1'b1;
          e_wo  = x_r;
          e_nsp = sp_r - 1'b1;
        end else if (m_r == SIO_READ) begin
          e_nsp = sp_r + 1'b1;
          e_wa  = sp_r + 1'b1;
          e_wd  = rv_r;
          e_nw1 = 1'b1;
        end else if (m_r == SIO_HALT) begin
          e_hl = 1'b1;
        end
      end
      OP_HLT: e_hl = (m_r == HLT_CODE);
      default: e_hl = 1'b0;
    endcase
  end

  smis_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.exe && e_isdiv && (y != '0)),
    .dividend (x_r),
    .divisor  (y),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_rem)
  );

  assign pc_ok = in_code(npc_r);

  // frame record written by a call
  always_comb begin
    case (wk_r)
      2'd0:    cal_d = '0;
      2'd1:    cal_d = b_r;
      2'd2:    cal_d = {{(WORD_W-SP_W){1'b0}}, bp_r};
      default: cal_d = {{(WORD_W-PC_W-1){1'b0}}, pc1};
    endcase
  end

  // memory port selection
  always_comb begin
    if (cmd.walk_step)  raddr = SP_W'(b_x + XW'(1));
    else if (cmd.chk)   raddr = p_ra;
    else if (cmd.rd2)   raddr = p_rb;
    else                raddr = sp_r;
    we    = cmd.clr || cmd.wr;
    waddr = cmd.clr ? clr_r : (wa_r + {{(SP_W-2){1'b0}}, wk_r});
    wdata = cmd.clr ? '0 : (nw4_r ? cal_d : wd_r);
  end

  always_ff @(posedge clk) begin
    if (we) stk_mem[waddr] <= wdata;
    rdata_r <= stk_mem[raddr];
  end

  // machine registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r      <= '0;
      bp_r      <= SP_W'(1);
      pc_r      <= '0;
      halt_r    <= 1'b0;
      clr_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + 1'b1;
      if (cmd.fin && !sts.commit_ok) halt_r <= 1'b1;
      if (cmd.cmt) begin
        sp_r <= nsp_r;
        bp_r <= nbp_r;
        pc_r <= npc_r[PC_W-1:0];
        if (hl_r) halt_r <= 1'b1;
      end
      if (cmd.out_ld)     out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  // per-instruction registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_data.cmd;
      m_r     <= in_data.operand;
      rv_r    <= in_data.read_value;
      b_r     <= {{(WORD_W-SP_W){1'b0}}, bp_r};
      cnt_r   <= (in_data.cmd == OP_LOD || in_data.cmd == OP_STO ||
                  in_data.cmd == OP_CAL) ? lvl_c : '0;
      fault_r <= FLT_NONE;
      wv_r    <= 1'b0;
      wk_r    <= '0;
    end
    if (cmd.walk_step && walk_bad) fault_r <= FLT_STACK;
    if (cmd.walk_ld) begin
      b_r   <= rdata_r;
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.chk && p_bad) fault_r <= FLT_STACK;
    if (cmd.rd2) x_r <= rdata_r;
    if (cmd.exe) begin
      nsp_r <= e_nsp;
      nbp_r <= e_nbp;
      npc_r <= e_npc;
      wa_r  <= e_wa;
      wd_r  <= e_wd;
      wo_r  <= e_wo;
      nw1_r <= e_nw1;
      nw4_r <= e_nw4;
      hl_r  <= e_hl;
      wv_r  <= e_wv;
      if (e_bad)                      fault_r <= FLT_STACK;
      else if (e_isdiv && y == '0)    fault_r <= FLT_DIV0;
    end
    if (cmd.div_ld) wd_r <= (m_r[3:0] == OPR_DIV) ? div_q : div_rem;
    if (cmd.fin && fault_r == FLT_NONE && !pc_ok) fault_r <= FLT_PC;
    if (cmd.wr) wk_r <= wk_r + 1'b1;
    if (cmd.out_ld) begin
      out_r.next_pc       <= pc_r;
      out_r.frame_base    <= bp_r;
      out_r.stack_pointer <= sp_r;
      out_r.top_value     <= rdata_r;
      out_r.write_valid   <= wv_r && (fault_r == FLT_NONE);
      out_r.write_value   <= (wv_r && (fault_r == FLT_NONE)) ? wo_r : '0;
      out_r.halted        <= halt_r;
      out_r.fault         <= fault_r;
    end
  end

  // status
  always_comb begin
    sts.clr_last  = (clr_r == SP_W'(STACK_DEPTH - 1));
    sts.halted    = halt_r;
    sts.walk_zero = (cnt_r == '0);
    sts.walk_bad  = walk_bad;
    sts.stk_bad   = p_bad;
    sts.need_div  = e_isdiv && (y != '0);
    sts.div_done  = div_done;
    sts.commit_ok = (fault_r == FLT_NONE) && pc_ok;
    sts.has_wr    = nw1_r || nw4_r;
    sts.wr_last   = !nw4_r || (wk_r == 2'd3);
    sts.out_free  = !out_vld_r || out_ready;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/smis_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smis_ctrl
// Sequencer: clearing pass, link walk, reads, execute, divide, write-back.
// ----------------------------------------------------------------------------
module smis_ctrl
  import smis_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire smis_sts_t sts,
  output smis_cmd_t      cmd
);

  smis_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.halted ? ST_TOP : ST_WALK;
        end
      end
      // one static-link hop per pass through ST_WALK and ST_WALK_W
      ST_WALK: begin
        if (sts.walk_zero) begin
          state_nxt = ST_CHECK;
        end else begin
          cmd.walk_step = 1'b1;
          state_nxt     = sts.walk_bad ? ST_FIN : ST_WALK_W;
        end
      end
      ST_WALK_W: begin
        cmd.walk_ld = 1'b1;
        state_nxt   = ST_WALK;
      end
      ST_CHECK: begin
        cmd.chk   = 1'b1;
        state_nxt = sts.stk_bad ? ST_FIN : ST_RD2;
      end
      ST_RD2: begin
        cmd.rd2   = 1'b1;
        state_nxt = ST_EXE;
      end
      ST_EXE: begin
        cmd.exe   = 1'b1;
        state_nxt = sts.need_div ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_ld = 1'b1;
          state_nxt  = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        if (!sts.commit_ok)  state_nxt = ST_TOP;
        else if (sts.has_wr) state_nxt = ST_WR;
        else                 state_nxt = ST_CMT;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        if (sts.wr_last) state_nxt = ST_CMT;
      end
      ST_CMT: begin
        cmd.cmt   = 1'b1;
        state_nxt = ST_TOP;
      end
      ST_TOP: state_nxt = ST_OUT;
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/stack_machine_instruction_step_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_instruction_step_core
// Executes one P-machine instruction per input beat on an on-chip data stack.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | cmd, level, operand, read_value
//  out_ch  | out | next_pc, frame_base, stack_pointer, top_value,
//          |     | write_valid, write_value, halted, fault
//
// An instruction runs from accept through the static-link walk, checks, reads,
// execute, the divider for DIV and MOD, write-back (one word, four for CAL),
// commit, top-of-stack read and result beat, all through a stack memory with
// one read and one write port. A faulting instruction skips write-back and
// commit; a halted machine's beat skips to the stack-top read. A clearing pass
// after reset zeroes the stack before the first beat is taken. One instruction
// is in flight at a time; a held result stalls the sequencer in its last step.
module stack_machine_instruction_step_core
  import smis_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst_n,
  smis_in_if.sink    in_ch,
  smis_out_if.source out_ch
);

  smis_cmd_t cmd;
  smis_sts_t sts;

  smis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smis_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the P-machine instruction step core. A directed
// table walks every opcode but HLT and every OPR operation but LEQ, then a long
// run of well-formed random instructions keeps the machine alive, and a final
// halting or faulting instruction closes the run. Every result beat is checked
// against an in-bench machine-state model, the first two against typed values.
// ----------------------------------------------------------------------------
module tb_top;
  import smis_pkg::*;

  localparam int  N_RANDOM   = 1700;
  localparam int  IDLE_PCT   = 28;
  localparam int  HOLD_BEAT  = 300;
  localparam int  HOLD_LEN   = 500;
  localparam int  WDOG_LIMIT = 12000;
  localparam int  END_WAIT   = 100;
  localparam logic [CMD_W-1:0] OP_UNUSED = 4'd14;

  // one instruction's effect before it is committed
  typedef struct {
    longint      sp;
    longint      bp;
    longint      pc;
    bit          hl;
    int          nw;
    longint      widx[4];
    logic [31:0] wval[4];
    bit          wv;
    logic [31:0] wout;
    fault_t      flt;
  } pm_step_t;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  smis_in_if  in_ch();
  smis_out_if out_ch();

  stack_machine_instruction_step_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // machine state mirror
  logic [31:0] vm_stack [STACK_DEPTH];
  longint      vm_sp;
  longint      vm_bp;
  longint      vm_pc;
  bit          vm_halt;

  out_item_t   due_results[$];
  stim_row_t   directed_rows[$];
  int          err_cnt;
  int          out_beats;
  bit          calm;
  bit          sent_all;

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic bit stk_ok(longint i);
    return i >= 0 && i < STACK_DEPTH;
  endfunction

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // follow the static links lev times
  function automatic bit link_walk(longint bp, int lev, output longint b);
    b = bp;
    for (int k = 0; k < lev; k++) begin
      if (!stk_ok(b + 1)) return 1'b0;
      b = sx(vm_stack[b + 1]);
    end
    return 1'b1;
  endfunction

  // work out one instruction without touching the state
  function automatic pm_step_t instr_effect(in_item_t it);
    pm_step_t    s;
    longint      m, b, a;
    logic [31:0] x, y, r;
    int          lev;
    s.sp = vm_sp; s.bp = vm_bp; s.pc = vm_pc + 1;
    s.hl = 0; s.nw = 0; s.wv = 0; s.wout = '0; s.flt = FLT_NONE;
    m = longint'(it.operand);
    lev = (it.level > MAX_LEVEL) ? MAX_LEVEL : it.level;
    b = 0; r = '0;
    if (vm_halt) return s;
    case (it.cmd)
      OP_LIT: begin
        if (!stk_ok(s.sp + 1)) s.flt = FLT_STACK;
        else begin
          s.sp++;
          s.widx[s.nw] = s.sp; s.wval[s.nw] = it.operand; s.nw++;
        end
      end
      OP_OPR: begin
        if (m == 0) begin
          if (!stk_ok(vm_bp - 1) || !stk_ok(vm_bp + 3)) s.flt = FLT_STACK;
          else begin
            s.pc = sx(vm_stack[vm_bp + 3]);
            a = sx(vm_stack[vm_bp + 2]);
            if (!stk_ok(a)) s.flt = FLT_STACK;
            else begin
              s.sp = vm_bp - 1;
              s.bp = a;
              if (s.sp < 1) s.hl = 1;
            end
          end
        end else if (m == 1 || m == 6) begin
          if (!stk_ok(s.sp)) s.flt = FLT_STACK;
          else begin
            x = vm_stack[s.sp];
            s.widx[s.nw] = s.sp;
            s.wval[s.nw] = (m == 1) ? (32'd0 - x) : {31'd0, x[0]};
            s.nw++;
          end
        end else if (m >= 2 && m <= 13) begin
          if (!stk_ok(s.sp) || s.sp < 1) s.flt = FLT_STACK;
          else begin
            x = vm_stack[s.sp - 1];
            y = vm_stack[s.sp];
            case (opr_t'(it.operand[3:0]))
              OPR_ADD: r = x + y;
              OPR_SUB: r = x - y;
              OPR_MUL: r = x * y;
              OPR_DIV, OPR_MOD: begin
                if (y == 0) s.flt = FLT_DIV0;
                else begin
                  a = (it.operand[3:0] == OPR_DIV) ? sx(x) / sx(y) : sx(x) % sx(y);
                  r = a[31:0];
                end
              end
              OPR_EQL: r = {31'd0, x == y};
              OPR_NEQ: r = {31'd0, x != y};
              OPR_LSS: r = {31'd0, $signed(x) < $signed(y)};
              OPR_LEQ: r = {31'd0, $signed(x) <= $signed(y)};
              OPR_GTR: r = {31'd0, $signed(x) > $signed(y)};
              default: r = {31'd0, $signed(x) >= $signed(y)};
            endcase
            if (s.flt == FLT_NONE) begin
              s.sp--;
              s.widx[s.nw] = s.sp; s.wval[s.nw] = r; s.nw++;
            end
          end
        end
      end
      OP_LOD: begin
        if (!link_walk(vm_bp, lev, b)) s.flt = FLT_STACK;
        else begin
          a = b + m;
          if (!stk_ok(a) || !stk_ok(s.sp + 1)) s.flt = FLT_STACK;
          else begin
            s.sp++;
            s.widx[s.nw] = s.sp; s.wval[s.nw] = vm_stack[a]; s.nw++;
          end
        end
      end
      OP_STO: begin
        if (!link_walk(vm_bp, lev, b)) s.flt = FLT_STACK;
        else begin
          a = b + m;
          if (!stk_ok(a) || !stk_ok(s.sp) || s.sp < 1) s.flt = FLT_STACK;
          else begin
            s.widx[s.nw] = a; s.wval[s.nw] = vm_stack[s.sp]; s.nw++;
            s.sp--;
          end
        end
      end
      OP_CAL: begin
        if (!link_walk(vm_bp, lev, b) || !stk_ok(s.sp) || !stk_ok(s.sp + 4))
          s.flt = FLT_STACK;
        else begin
          s.widx[0] = s.sp + 1; s.wval[0] = '0;
          s.widx[1] = s.sp + 2; s.wval[1] = b[31:0];
          s.widx[2] = s.sp + 3; s.wval[2] = vm_bp[31:0];
          s.widx[3] = s.sp + 4; s.wval[3] = s.pc[31:0];
          s.nw = 4;
          s.bp = s.sp + 1;
          s.pc = m;
        end
      end
      OP_INC: begin
        if (!stk_ok(s.sp + m)) s.flt = FLT_STACK;
        else s.sp += m;
      end
      OP_JMP: s.pc = m;
      OP_JPC: begin
        if (!stk_ok(s.sp) || s.sp < 1) s.flt = FLT_STACK;
        else begin
          if (vm_stack[s.sp] == 0) s.pc = m;
          s.sp--;
        end
      end
      OP_SIO: begin
        if (it.operand == SIO_WRITE) begin
          if (!stk_ok(s.sp) || s.sp < 1) s.flt = FLT_STACK;
          else begin
            s.wv = 1;
            s.wout = vm_stack[s.sp];
            s.sp--;
          end
        end else if (it.operand == SIO_READ) begin
          if (!stk_ok(s.sp + 1)) s.flt = FLT_STACK;
          else begin
            s.sp++;
            s.widx[s.nw] = s.sp; s.wval[s.nw] = it.read_value; s.nw++;
          end
        end else if (it.operand == SIO_HALT) begin
          s.hl = 1;
        end
      end
      OP_HLT: if (it.operand == HLT_CODE) s.hl = 1;
      default: ;
    endcase
    if (s.flt == FLT_NONE && (s.pc < 0 || s.pc >= CODE_DEPTH)) s.flt = FLT_PC;
    return s;
  endfunction

  // apply an effect and return the result beat it produces
  function automatic out_item_t instr_commit(pm_step_t s);
    out_item_t r;
    bit        was_halted;
    was_halted = vm_halt;
    if (!was_halted) begin
      if (s.flt != FLT_NONE) vm_halt = 1;
      else begin
        for (int i = 0; i < s.nw; i++)
          if (stk_ok(s.widx[i])) vm_stack[s.widx[i]] = s.wval[i];
        vm_sp = s.sp;
        vm_bp = s.bp;
        vm_pc = s.pc;
        if (s.hl) vm_halt = 1;
      end
    end
    r.next_pc       = PC_W'(vm_pc);
    r.frame_base    = SP_W'(vm_bp);
    r.stack_pointer = SP_W'(vm_sp);
    r.top_value     = vm_stack[vm_sp];
    r.write_valid   = !was_halted && s.flt == FLT_NONE && s.wv;
    r.write_value   = r.write_valid ? s.wout : '0;
    r.halted        = vm_halt;
    r.fault         = was_halted ? FLT_NONE : s.flt;
    return r;
  endfunction

  function automatic in_item_t mk_instr(logic [3:0] c, logic [3:0] l, logic [31:0] o,
                                        logic [31:0] v = '0);
    in_item_t it;
    it.cmd = c; it.level = l; it.operand = o; it.read_value = v;
    return it;
  endfunction

  // random instruction, biased towards programs that keep running
  function automatic in_item_t rand_instr();
    in_item_t it;
    int       sel;
    sel = $urandom_range(99);
    it = mk_instr(OP_LIT, 4'($urandom_range(15)), $urandom, $urandom);
    if (sel < 20) begin
      it.cmd = OP_LIT;
      if ($urandom_range(1)) it.operand = $urandom_range(20) - 10;
    end else if (sel < 45) begin
      it.cmd = OP_OPR;  it.operand = $urandom_range(13);
    end else if (sel < 62) begin
      it.cmd = (sel < 55) ? OP_LOD : OP_STO;
      it.level = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2));
      it.operand = $urandom_range(8) - 1;
    end else if (sel < 67) begin
      it.cmd = OP_CAL;  it.level = 4'($urandom_range(2));
      it.operand = $urandom_range(CODE_DEPTH - 1);
    end else if (sel < 72) begin
      it.cmd = OP_INC;  it.operand = $urandom_range(9) - 3;
    end else if (sel < 82) begin
      it.cmd = (sel < 77) ? OP_JMP : OP_JPC;
      it.operand = $urandom_range(CODE_DEPTH - 1);
    end else if (sel < 90) begin
      it.cmd = OP_SIO;  it.operand = $urandom_range(1);
    end else if (sel < 95) begin
      // codes that only advance the pc
      case ($urandom_range(3))
        0: it.cmd = OP_UNUSED;
        1: begin it.cmd = OP_OPR; it.operand = 14 + $urandom_range(50); end
        2: begin it.cmd = OP_SIO; it.operand = 3 + $urandom_range(50); end
        default: begin it.cmd = OP_HLT; it.operand = $urandom; end
      endcase
    end else begin
      it.cmd = 4'($urandom_range(15));
    end
    return it;
  endfunction

  // draw until the instruction neither halts nor faults, else fall back to a jump
  task automatic gen_live(output in_item_t it, output out_item_t r);
    pm_step_t s;
    for (int tries = 0; tries < 60; tries++) begin
      it = rand_instr();
      s = instr_effect(it);
      if (s.flt == FLT_NONE && !s.hl) break;
    end
    if (s.flt != FLT_NONE || s.hl) begin
      it = mk_instr(OP_JMP, 4'($urandom_range(15)), $urandom_range(20), $urandom);
      s = instr_effect(it);
    end
    r = instr_commit(s);
  endtask

  // offer one instruction beat and book its result once it is taken
  task automatic send_beat(in_item_t it, out_item_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    due_results.push_back(want);
  endtask

  task automatic add_row(logic [3:0] c, logic [3:0] l, logic [31:0] o,
                         logic [31:0] v = '0);
    stim_row_t row;
    row.it = mk_instr(c, l, o, v);
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endtask

  // reset and stimulus
  initial begin
    in_item_t  it;
    out_item_t r;
    pm_step_t  s;
    in_item_t  ending[$];
    stim_row_t row;

    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    rst_n       <= 1'b0;
    calm = 0; sent_all = 0;
    for (int i = 0; i < STACK_DEPTH; i++) vm_stack[i] = '0;
    vm_sp = 0; vm_bp = 1; vm_pc = 0; vm_halt = 0;

    // directed table: extremes first, then every operation but OPR LEQ and HLT
    row.it = mk_instr(OP_LIT, 0, 32'h7fff_ffff);
    row.typed = 1'b1;
    row.want = '{next_pc: 1, frame_base: 1, stack_pointer: 1, top_value: 32'h7fff_ffff,
                 write_valid: 0, write_value: 0, halted: 0, fault: FLT_NONE};
    directed_rows.push_back(row);
    row.it = mk_instr(OP_LIT, 0, 32'h8000_0000);
    row.want = '{next_pc: 2, frame_base: 1, stack_pointer: 2, top_value: 32'h8000_0000,
                 write_valid: 0, write_value: 0, halted: 0, fault: FLT_NONE};
    directed_rows.push_back(row);
    add_row(OP_OPR, 0, OPR_ADD);
    add_row(OP_OPR, 0, OPR_NEG);
    add_row(OP_OPR, 0, OPR_ODD);
    add_row(OP_LIT, 0, -7);
    add_row(OP_LIT, 0, 2);
    add_row(OP_OPR, 0, OPR_DIV);
    add_row(OP_LIT, 0, -3);
    add_row(OP_OPR, 0, OPR_MOD);
    add_row(OP_OPR, 0, OPR_MUL);
    add_row(OP_LIT, 0, 5);
    add_row(OP_OPR, 0, OPR_SUB);
    add_row(OP_LIT, 0, 0);
    add_row(OP_OPR, 0, OPR_LSS);
    add_row(OP_INC, 0, 4);
    add_row(OP_OPR, 0, OPR_EQL);
    add_row(OP_OPR, 0, OPR_NEQ);
    add_row(OP_OPR, 0, OPR_GTR);
    add_row(OP_OPR, 0, OPR_GEQ);
    add_row(OP_SIO, 0, SIO_READ, 32'h8000_0001);
    add_row(OP_STO, 0, 3);
    add_row(OP_LOD, 0, 3);
    add_row(OP_SIO, 0, SIO_WRITE);
    add_row(OP_JPC, 0, 40);
    add_row(OP_INC, 0, 2);
    add_row(OP_CAL, 0, 100);
    add_row(OP_OPR, 0, OPR_RET);
    add_row(OP_JMP, 0, 7);
    add_row(OP_UNUSED, 4'hf, 32'hffff_ffff, 32'hffff_ffff);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      s = instr_effect(directed_rows[i].it);
      r = instr_commit(s);
      send_beat(directed_rows[i].it, directed_rows[i].typed ? directed_rows[i].want : r);
    end

    // random program body
    for (int k = 0; k < N_RANDOM; k++) begin
      calm = (k >= 600 && k < 900);
      if (k == 1000) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
      end
      gen_live(it, r);
      send_beat(it, r);
    end
    calm = 0;

    // one ending: a fault or a halt, then a few beats on the halted machine
    case ($urandom_range(5))
      0: begin
        ending.push_back(mk_instr(OP_INC, 0, 2));
        ending.push_back(mk_instr(OP_LIT, 0, 0));
        ending.push_back(mk_instr(OP_OPR, 0, OPR_DIV));
      end
      1: ending.push_back(mk_instr(OP_INC, 0, -4096));
      2: ending.push_back(mk_instr(OP_JMP, 0, CODE_DEPTH + 88));
      3: ending.push_back(mk_instr(OP_JMP, 0, -1));
      4: ending.push_back(mk_instr(OP_HLT, 0, HLT_CODE));
      default: ending.push_back(mk_instr(OP_SIO, 0, SIO_HALT));
    endcase
    repeat (4) ending.push_back(rand_instr());
    foreach (ending[i]) begin
      s = instr_effect(ending[i]);
      r = instr_commit(s);
      send_beat(ending[i], r);
    end
    in_ch.valid <= 1'b0;
    sent_all = 1;
  end

  // result side: check each beat, random back-pressure, one long hold-off
  initial begin
    int  hold_left;
    bit  held_once;
    out_item_t want;
    out_ch.ready <= 1'b0;
    hold_left = 0; held_once = 0;
    err_cnt = 0; out_beats = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        out_beats++;
        if (due_results.size() == 0) begin
          $error("result beat with nothing outstanding");
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          if (out_ch.data.next_pc !== want.next_pc) begin
            $error("next_pc: expected %0d, got %0d", want.next_pc, out_ch.data.next_pc);
            err_cnt++;
          end
          if (out_ch.data.frame_base !== want.frame_base) begin
            $error("frame_base: expected %0d, got %0d", want.frame_base,
                   out_ch.data.frame_base);
            err_cnt++;
          end
          if (out_ch.data.stack_pointer !== want.stack_pointer) begin
            $error("stack_pointer: expected %0d, got %0d", want.stack_pointer,
                   out_ch.data.stack_pointer);
            err_cnt++;
          end
          if (out_ch.data.top_value !== want.top_value) begin
            $error("top_value: expected %0h, got %0h", want.top_value,
                   out_ch.data.top_value);
            err_cnt++;
          end
          if (out_ch.data.write_valid !== want.write_valid) begin
            $error("write_valid: expected %0d, got %0d", want.write_valid,
                   out_ch.data.write_valid);
            err_cnt++;
          end
          if (out_ch.data.write_value !== want.write_value) begin
            $error("write_value: expected %0h, got %0h", want.write_value,
                   out_ch.data.write_value);
            err_cnt++;
          end
          if (out_ch.data.halted !== want.halted) begin
            $error("halted: expected %0d, got %0d", want.halted, out_ch.data.halted);
            err_cnt++;
          end
          if (out_ch.data.fault !== want.fault) begin
            $error("fault: expected %0d, got %0d", want.fault, out_ch.data.fault);
            err_cnt++;
          end
        end
      end
      if (!held_once && out_beats == HOLD_BEAT) begin
        held_once = 1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // end of run
  initial begin
    @(posedge clk);
    while (!sent_all || due_results.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
